/* src/mv4_pkg.sv */
// Package for the 4x4 float32 matrix-vector transform.
// Float32 class codes, rounding and leading-zero helpers; no dependencies.
package mv4_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegW     = 64;
  localparam int unsigned IdxW     = 3;
  // Pipeline depth: three multiply stages plus three chained three-stage adders.
  localparam int unsigned Lat      = 12;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;

  typedef enum logic [1:0] {
    K_FIN,
    K_ZERO,
    K_INF,
    K_NAN
  } fpk_t;

  // Leading zeros of a nonzero 48-bit magnitude.
  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Round to nearest even and pack. n has its leading one at bit 47, be is the
  // biased exponent of that bit; below one the value goes subnormal.
  function automatic logic [31:0] round_pack(input logic s, input logic [47:0] n,
                                             input logic signed [11:0] be);
    logic [5:0]  sh;
    logic [73:0] full;
    logic [73:0] t;
    logic [73:0] mask;
    logic        lost;
    logic        g;
    logic        st;
    logic        inc;
    logic [23:0] m;
    logic [11:0] bef;
    logic [34:0] w;
    if (be < 12'sd1) begin
      if (be < -12'sd61) sh = 6'd63;
      else sh = 6'(12'sd1 - be);
      bef = 12'd0;
    end else begin
      sh  = 6'd0;
      bef = 12'(be - 12'sd1);
    end
    full = {n, 26'b0};
    t    = full >> sh;
    mask = (74'd1 << sh) - 74'd1;
    lost = |(full & mask);
    m    = t[73:50];
    g    = t[49];
    st   = (|t[48:0]) | lost;
    inc  = g & (st | m[0]);
    w    = {bef, 23'b0} + 35'(m) + 35'(inc);
    if (w >= 35'(InfMag)) return {s, InfMag};
    return {s, w[30:0]};
  endfunction

endpackage

/* src/mv4_if.sv */
// Stream interfaces for the transform: input vector and result channel.
// Depends on nothing.
interface mv4_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  vec_index;
  logic [31:0] in_e0;
  logic [31:0] in_e1;
  logic [31:0] in_e2;
  logic [31:0] in_e3;
  modport source (output valid, vec_index, in_e0, in_e1, in_e2, in_e3, input ready);
  modport sink   (input valid, vec_index, in_e0, in_e1, in_e2, in_e3, output ready);
endinterface

interface mv4_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_index;
  logic [31:0] out_e0;
  logic [31:0] out_e1;
  logic [31:0] out_e2;
  logic [31:0] out_e3;
  modport source (output valid, out_index, out_e0, out_e1, out_e2, out_e3, input ready);
  modport sink   (input valid, out_index, out_e0, out_e1, out_e2, out_e3, output ready);
endinterface

/* src/mv4_fp_mul.sv */
// Three-stage float32 multiplier: multiply, leading-zero count, normalize/round.
// Depends on mv4_pkg.
module mv4_fp_mul import mv4_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        za, zb, ia, ib, na, nb;
  logic [7:0]  xa, xb;
  fpk_t        k_nxt;

  logic               s_a_r, s_b_r;
  fpk_t               k_a_r, k_b_r;
  logic signed [11:0] be_a_r, be_b_r;
  logic [47:0]        p_a_r, p_b_r;
  logic [5:0]         lz_b_r;
  logic [31:0]        y_r;
  logic [31:0]        y_nxt;

  always_comb begin
    za = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
    zb = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    if (na || nb || (ia && zb) || (ib && za)) k_nxt = K_NAN;
    else if (ia || ib) k_nxt = K_INF;
    else if (za || zb) k_nxt = K_ZERO;
    else k_nxt = K_FIN;
  end

  always_comb begin
    case (k_b_r)
      K_NAN:   y_nxt = CanonNan;
      K_INF:   y_nxt = {s_b_r, InfMag};
      K_ZERO:  y_nxt = {s_b_r, 31'd0};
      default: y_nxt = round_pack(s_b_r, p_b_r << lz_b_r, be_b_r - 12'(lz_b_r));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r  <= a[31] ^ b[31];
      k_a_r  <= k_nxt;
      be_a_r <= 12'(xa) + 12'(xb) - 12'sd126;
      p_a_r  <= {24'd0, |a[30:23], a[22:0]} * {24'd0, |b[30:23], b[22:0]};
      s_b_r  <= s_a_r;
      k_b_r  <= k_a_r;
      be_b_r <= be_a_r;
      p_b_r  <= p_a_r;
      lz_b_r <= lzc48(p_a_r);
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* src/mv4_fp_add.sv */
// Three-stage float32 adder: align and add, leading-zero count, normalize/round.
// Depends on mv4_pkg.
module mv4_fp_add import mv4_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        ia, ib, na, nb, swp;
  logic [31:0] bg, sm;
  logic [7:0]  xg, xs, d;
  logic [26:0] gx, sx, shx, msk;
  logic        stk;
  logic [27:0] sum;
  fpk_t        k_nxt;
  logic        s_nxt;

  logic               s_a_r, s_b_r, z_a_r, z_b_r;
  fpk_t               k_a_r, k_b_r;
  logic signed [11:0] be_a_r, be_b_r;
  logic [27:0]        m_a_r, m_b_r;
  logic [5:0]         lz_b_r;
  logic [31:0]        y_r;
  logic [31:0]        y_nxt;

  always_comb begin
    ia  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    na  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    swp = b[30:0] > a[30:0];
    bg  = swp ? b : a;
    sm  = swp ? a : b;
    xg  = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    xs  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d   = xg - xs;
    gx  = {|bg[30:23], bg[22:0], 3'b0};
    sx  = {|sm[30:23], sm[22:0], 3'b0};
    if (d >= 8'd27) begin
      msk = '0;
      shx = 27'd0;
      stk = |sx;
    end else begin
      msk = (27'd1 << d) - 27'd1;
      shx = sx >> d;
      stk = |(sx & msk);
    end
    if (bg[31] == sm[31]) sum = 28'(gx) + 28'({shx[26:1], shx[0] | stk});
    else sum = 28'(gx) - 28'({shx[26:1], shx[0] | stk});
    if (na || nb || (ia && ib && (a[31] != b[31]))) begin
      k_nxt = K_NAN;
      s_nxt = 1'b0;
    end else if (ia || ib) begin
      k_nxt = K_INF;
      s_nxt = ia ? a[31] : b[31];
    end else begin
      k_nxt = K_FIN;
      s_nxt = bg[31];
    end
  end

  always_comb begin
    case (k_b_r)
      K_NAN:   y_nxt = CanonNan;
      K_INF:   y_nxt = {s_b_r, InfMag};
      K_ZERO:  y_nxt = {z_b_r, 31'd0};
      default: begin
        if (m_b_r == 28'd0) y_nxt = {z_b_r, 31'd0};
        else y_nxt = round_pack(s_b_r, {m_b_r, 20'd0} << lz_b_r, be_b_r - 12'(lz_b_r));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r  <= s_nxt;
      z_a_r  <= a[31] & b[31];
      k_a_r  <= k_nxt;
      be_a_r <= 12'(xg) + 12'sd1;
      m_a_r  <= sum;
      s_b_r  <= s_a_r;
      z_b_r  <= z_a_r;
      k_b_r  <= k_a_r;
      be_b_r <= be_a_r;
      m_b_r  <= m_a_r;
      lz_b_r <= lzc48({m_a_r, 20'd0});
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* src/mat4_vector_transform.sv */
// Top level of the 4x4 float32 matrix-vector transform.
// Depends on mv4_pkg, mv4_if, mv4_fp_mul and mv4_fp_add.
//
//  channel   dir  handshake      payload
//  in_vec    in   valid/ready    vec_index, in_e0..in_e3
//  out_vec   out  valid/ready    out_index, out_e0..out_e3
//  cfg_*     in   cfg_we         cfg_index (3b), cfg_data (64b)
//
// One vector per cycle while the output takes results: three stages of multiply, then
// three chained adders of three stages each (rounded at every step, k=0..3).
// Reset clears the matrix registers and all valid bits.
// A stall freezes the whole pipeline, bubbles included, while the last stage
// holds a result that is not taken; the input is held off for that time.
module mat4_vector_transform import mv4_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  mv4_in_if.sink              in_vec,
  mv4_out_if.source           out_vec,
  input  logic                cfg_we,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [RegW-1:0]     cfg_data
);

  logic [RegW-1:0] mat_r [NumRegs];
  logic [Lat-1:0]  vld_r;
  logic [1:0]      idx_r [Lat];
  logic            en;

  logic [31:0] v   [4];
  logic [31:0] prd [4][4];
  logic [31:0] s1  [4];
  logic [31:0] s2  [4];
  logic [31:0] s3  [4];
  logic [31:0] p2d_r [4][3];
  logic [31:0] p3d_r [4][6];

  // Advance when the last stage is empty or its result transfers.
  assign en           = !vld_r[Lat-1] || out_vec.ready;
  assign in_vec.ready = en;

  assign v[0] = in_vec.in_e0;
  assign v[1] = in_vec.in_e1;
  assign v[2] = in_vec.in_e2;
  assign v[3] = in_vec.in_e3;

  // Matrix registers; the user must write them only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) mat_r[i] <= '0;
    end else if (cfg_we) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  // Valid bits and index travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_vec.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= in_vec.vec_index;
      for (int i = 1; i < Lat; i++) idx_r[i] <= idx_r[i-1];
    end
  end

  // Products v[k]*M[k][j]; M[k][j] sits in register 2k+j/2, half j%2.
  for (genvar k = 0; k < 4; k++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      mv4_fp_mul u_mul (
        .clk (clk),
        .en  (en),
        .a   (v[k]),
        .b   (mat_r[2*k + j/2][32*(j%2) +: 32]),
        .y   (prd[k][j])
      );
    end
  end

  // Hold the later products until their adder comes up.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        p2d_r[j][0] <= prd[2][j];
        for (int i = 1; i < 3; i++) p2d_r[j][i] <= p2d_r[j][i-1];
        p3d_r[j][0] <= prd[3][j];
        for (int i = 1; i < 6; i++) p3d_r[j][i] <= p3d_r[j][i-1];
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_sum
    mv4_fp_add u_add1 (.clk(clk), .en(en), .a(prd[0][j]), .b(prd[1][j]), .y(s1[j]));
    mv4_fp_add u_add2 (.clk(clk), .en(en), .a(s1[j]), .b(p2d_r[j][2]), .y(s2[j]));
    mv4_fp_add u_add3 (.clk(clk), .en(en), .a(s2[j]), .b(p3d_r[j][5]), .y(s3[j]));
  end

  assign out_vec.valid     = vld_r[Lat-1];
  assign out_vec.out_index = idx_r[Lat-1];
  assign out_vec.out_e0    = s3[0];
  assign out_vec.out_e1    = s3[1];
  assign out_vec.out_e2    = s3[2];
  assign out_vec.out_e3    = s3[3];

`ifndef NO_ASSERTIONS
  // A frozen pipeline keeps its valid bits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(!en) |-> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // Any NaN leaving the block on out_e0 is the canonical one.
  a_nan0: assert property (@(posedge clk) disable iff (!rst_n)
    out_vec.valid && (out_vec.out_e0[30:23] == 8'hFF) && (out_vec.out_e0[22:0] != 23'd0)
    |-> out_vec.out_e0 == CanonNan)
    else $error("non-canonical NaN on out_e0");

  // A result stalled at the output stays valid and its out_e3 is not overwritten.
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_vec.valid && !out_vec.ready |=> out_vec.valid && $stable(out_vec.out_e3))
    else $error("stalled result changed");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for mat4_vector_transform, the 4x4 float32 transform.
// Depends on mv4_pkg and the mv4_in_if / mv4_out_if stream interfaces.
// A bit-exact float32 predictor checks every transfer on the result channel.
module testbench;
  import mv4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Configuration register map: row K, element pair 01 or 23.
  typedef enum logic [IdxW-1:0] {
    REG_R0_C01, REG_R0_C23, REG_R1_C01, REG_R1_C23,
    REG_R2_C01, REG_R2_C23, REG_R3_C01, REG_R3_C23
  } mat_reg_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
  } vec_t;

  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_MAX  = 32'h7F7F_FFFF;
  localparam logic [31:0] F_INF  = 32'h7F80_0000;
  localparam logic [31:0] F_NINF = 32'hFF80_0000;
  localparam logic [31:0] F_SNAN = 32'hFF80_0001;
  localparam logic [31:0] F_SUBN = 32'h0000_0001;
  localparam logic [31:0] F_SUBX = 32'h807F_FFFF;
  localparam logic [31:0] F_MINN = 32'h0080_0000;
  localparam logic [31:0] F_NZERO = 32'h8000_0000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [RegW-1:0] cfg_data;

  mv4_in_if  in_if ();
  mv4_out_if out_if ();

  mat4_vector_transform u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vec    (in_if.sink),
    .out_vec   (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Testbench copy of the matrix, mirrored on every register write.
  logic [RegW-1:0] mat_q [NumRegs];

  vec_t pend_q[$];      // vectors waiting to be offered
  vec_t dot_q[$];       // expected transformed vectors, oldest first
  int   errors;
  bit   quiet;          // no idling on either side
  bit   hold_req;       // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Float32 arithmetic, exact then rounded once to nearest even.
  // ---------------------------------------------------------------------------
  function automatic bit f32_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit f32_inf(input logic [31:0] b);
    return b[30:0] == F_INF[30:0];
  endfunction

  // Split into integer significand and exponent of its lsb.
  function automatic void f32_split(input logic [31:0] b, output logic [127:0] m,
                                    output int e);
    m = '0;
    if (b[30:23] == 0) begin
      m[22:0] = b[22:0];
      e = -149;
    end else begin
      m[23:0] = {1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  // Round the value m * 2^e to binary32.
  function automatic logic [31:0] f32_round(input logic s, input logic [127:0] m,
                                            input int e);
    int p;
    int q;
    int sh;
    logic [127:0] mr;
    logic [127:0] rem;
    logic [127:0] half;
    if (m == 0) return {s, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    q = e + p - 23;
    if (q < -149) q = -149;
    sh = q - e;
    if (sh <= 0) begin
      mr = m << (-sh);
    end else if (sh >= 120) begin
      // far below half an ulp of the smallest subnormal
      mr = '0;
    end else begin
      mr   = m >> sh;
      rem  = m & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && mr[0])) mr = mr + 128'd1;
    end
    if (mr[24]) begin
      mr = mr >> 1;
      q++;
    end
    if (mr[23]) begin
      if (q + 150 >= 255) return {s, F_INF[30:0]};
      return {s, 8'(q + 150), mr[22:0]};
    end
    return {s, 8'd0, mr[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    if (f32_nan(a) || f32_nan(b)) return CanonNan;
    if (f32_inf(a) || f32_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return CanonNan;
      return {a[31] ^ b[31], F_INF[30:0]};
    end
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    return f32_round(a[31] ^ b[31], ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mt;
    logic [127:0] mag;
    int ea;
    int eb;
    int et;
    logic sa;
    logic sb;
    logic st;
    if (f32_nan(a) || f32_nan(b)) return CanonNan;
    if (f32_inf(a) && f32_inf(b)) return (a[31] != b[31]) ? CanonNan : a;
    if (f32_inf(a)) return a;
    if (f32_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    sa = a[31];
    sb = b[31];
    if (eb > ea) begin
      mt = ma; ma = mb; mb = mt;
      et = ea; ea = eb; eb = et;
      st = sa; sa = sb; sb = st;
    end
    if (ea - eb > 50) begin
      // the smaller term only acts as a sticky bit
      ma = ma << 50;
      ea = ea - 50;
      if (mb != 0) mb = 128'd1;
    end else begin
      ma = ma << (ea - eb);
      ea = eb;
    end
    if (sa == sb) begin
      mag = ma + mb;
      st  = sa;
    end else if (ma >= mb) begin
      mag = ma - mb;
      st  = sa;
    end else begin
      mag = mb - ma;
      st  = sb;
    end
    if (mag == 0) return 32'h0;
    return f32_round(st, mag, ea);
  endfunction

  function automatic logic [31:0] mat_elem(input int row, input int col);
    return mat_q[2 * row + col / 2][(col % 2) * 32 +: 32];
  endfunction

  // Dot of the vector with column col, products and sums rounded, k = 0..3.
  function automatic logic [31:0] column_dot(input vec_t v, input int col);
    logic [31:0] comp [4];
    logic [31:0] acc;
    comp = '{v.e0, v.e1, v.e2, v.e3};
    acc = f32_mul(comp[0], mat_elem(0, col));
    for (int k = 1; k < 4; k++) acc = f32_add(acc, f32_mul(comp[k], mat_elem(k, col)));
    return acc;
  endfunction

  function automatic vec_t transform_vec(input vec_t v);
    vec_t r;
    r.idx = v.idx;
    r.e0  = column_dot(v, 0);
    r.e1  = column_dot(v, 1);
    r.e2  = column_dot(v, 2);
    r.e3  = column_dot(v, 3);
    return r;
  endfunction

  // Random float: specials, edge patterns, raw bits, and values in a narrow
  // exponent band so that sums cancel and round in interesting ways.
  function automatic logic [31:0] rand_f32();
    logic s;
    s = 1'($urandom);
    case ($urandom_range(0, 11))
      0:  return {s, 31'b0};
      1:  return {s, F_INF[30:0]};
      2:  return $urandom_range(0, 1) ? CanonNan : {s, 8'hFF, 23'($urandom) | 23'd1};
      3:  return {s, 8'd0, 23'($urandom)};
      4:  return {s, 8'($urandom_range(1, 3)), 23'($urandom)};
      5:  return {s, 8'($urandom_range(250, 254)), 23'($urandom)};
      6:  return $urandom;
      default: return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer pending vectors, predict each accepted transfer.
  // ---------------------------------------------------------------------------
  int   send_gap;
  vec_t cur_vec;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) dot_q.push_back(transform_vec(cur_vec));
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur_vec         = pend_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.vec_index <= cur_vec.idx;
          in_if.in_e0     <= cur_vec.e0;
          in_if.in_e1     <= cur_vec.e1;
          in_if.in_e2     <= cur_vec.e2;
          in_if.in_e3     <= cur_vec.e3;
          // start an idle burst after this transfer now and then
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls plus one long hold-off, then check each transfer.
  // ---------------------------------------------------------------------------
  int   stall_cnt;
  bit   hold_done;
  vec_t got;
  vec_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_index, out_if.out_e0, out_if.out_e1, out_if.out_e2,
                out_if.out_e3};
        if (dot_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
          errors++;
        end else begin
          want = dot_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %h, actual %h", $realtime, want, got);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        // long hold-off: let the pipeline fill and back up into the input
        hold_done    <= 1'b1;
        stall_cnt    <= 400;
        out_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt    <= stall_cnt - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_cnt    <= $urandom_range(0, 14);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic write_reg(input mat_reg_t idx, input logic [RegW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    mat_q[idx] = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_matrix(input logic [31:0] el [16]);
    for (int r = 0; r < 4; r++) begin
      write_reg(mat_reg_t'(2 * r), {el[4 * r + 1], el[4 * r]});
      write_reg(mat_reg_t'(2 * r + 1), {el[4 * r + 3], el[4 * r + 2]});
    end
  endtask

  task automatic queue_vec(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
    pend_q.push_back('{2'($urandom), a, b, c, d});
  endtask

  // Hold until every vector went in and every result came out, then let the
  // pipeline settle for longer than its latency.
  task automatic drain();
    do @(posedge clk);
    while (pend_q.size() > 0 || in_if.valid || dot_q.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  logic [31:0] el [16];

  initial begin
    errors       = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_if.valid     = 1'b0;
    in_if.vec_index = '0;
    in_if.in_e0     = '0;
    in_if.in_e1     = '0;
    in_if.in_e2     = '0;
    in_if.in_e3     = '0;
    out_if.ready    = 1'b0;
    for (int i = 0; i < NumRegs; i++) mat_q[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset matrix is all zero: a few vectors through it first.
    queue_vec(F_ONE, F_MAX, F_NINF, 32'h0);
    queue_vec(F_SUBN, F_SUBX, F_NZERO, F_ONE);
    drain();

    // Identity matrix with edge vectors.
    for (int i = 0; i < 16; i++) el[i] = (i % 5 == 0) ? F_ONE : 32'h0;
    load_matrix(el);
    queue_vec(32'h0, F_NZERO, F_ONE, 32'hBF80_0000);
    queue_vec(F_MAX, F_MAX, F_MAX, F_MAX);
    queue_vec(F_INF, F_NINF, F_ONE, 32'h0);
    queue_vec(F_SNAN, CanonNan, 32'h7FFF_FFFF, F_ONE);
    queue_vec(F_SUBN, F_SUBX, F_MINN, 32'h807F_FFFF);
    queue_vec(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    drain();

    // All-ones column mix: sums of products, overflow, cancellation, subnormals.
    for (int i = 0; i < 16; i++) el[i] = F_ONE;
    el[1] = F_MAX; el[6] = 32'h4000_0000; el[11] = 32'h0080_0000; el[15] = 32'h3F00_0000;
    load_matrix(el);
    queue_vec(F_MAX, F_MAX, F_MAX, F_MAX);
    queue_vec(32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000);
    queue_vec(32'h3F80_0001, 32'hBF80_0000, 32'h3380_0000, 32'h0);
    queue_vec(F_INF, F_NINF, 32'h0, 32'h0);
    queue_vec(F_SUBN, F_SUBN, F_SUBX, F_SUBN);
    queue_vec(32'h4B80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    queue_vec(32'h0000_0001, F_MINN, 32'h3400_0000, 32'h0);
    queue_vec(F_NZERO, F_NZERO, F_NZERO, F_NZERO);
    drain();

    // Register extremes: all ones (NaN everywhere), then all zero.
    for (int i = 0; i < NumRegs; i++) write_reg(mat_reg_t'(i), '1);
    queue_vec(F_ONE, 32'h0, F_INF, F_SUBN);
    queue_vec(32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    for (int i = 0; i < NumRegs; i++) write_reg(mat_reg_t'(i), '0);
    queue_vec(F_INF, F_ONE, F_MAX, F_SUBX);
    drain();

    // Random phases: new matrix each time, the last one without idling.
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < 16; i++) el[i] = rand_f32();
      load_matrix(el);
      if (ph == 11) quiet = 1'b1;
      for (int n = 0; n < 145; n++)
        queue_vec(rand_f32(), rand_f32(), rand_f32(), rand_f32());
      if (ph == 2) hold_req = 1'b1;
      drain();
    end

    // Raw register bits, to toggle every data bit of the write port.
    for (int i = 0; i < NumRegs; i++) write_reg(mat_reg_t'(i), {$urandom, $urandom});
    for (int n = 0; n < 20; n++) queue_vec($urandom, $urandom, $urandom, $urandom);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/mv4_pkg.sv
src/mv4_if.sv
src/mv4_fp_mul.sv
src/mv4_fp_add.sv
src/mat4_vector_transform.sv
dv/testbench.sv
